/* src/bpd_pkg.sv */
package bpd_pkg;

  localparam int unsigned PressureWidth = 17;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned BandWidth     = 10;
  localparam int unsigned MinCycleWidth = 16;
  localparam int unsigned SectorWidth   = 3;
  localparam int unsigned RelWidth      = 18;
  localparam int unsigned SlopeWidth    = 23;
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned EventWidth    = 2;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 17;
  localparam int unsigned InDataWidth   = 56;
  localparam int unsigned OutDataWidth  = 96;

  localparam logic [CfgIndexWidth-1:0] REG_BASELINE  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DEAD_BAND = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MIN_CYCLE = 2'd2;

  localparam logic [PressureWidth-1:0] BASELINE_RESET  = 17'd101325;
  localparam logic [BandWidth-1:0]     DEAD_BAND_RESET = 10'd10;
  localparam logic [MinCycleWidth-1:0] MIN_CYCLE_RESET = 16'd1000;

  localparam logic signed [SectorWidth-1:0] SEC_REST       = 3'sd0;
  localparam logic signed [SectorWidth-1:0] SEC_RISE       = 3'sd1;
  localparam logic signed [SectorWidth-1:0] SEC_HIGH_FALL  = 3'sd2;
  localparam logic signed [SectorWidth-1:0] SEC_FALL       = -3'sd1;
  localparam logic signed [SectorWidth-1:0] SEC_LOW_RISE   = -3'sd2;

  localparam logic [CountWidth-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_BREATH = 2'd2
  } event_t;

  typedef struct packed {
    logic [MinCycleWidth-1:0] min_cycle_ms;
    logic [BandWidth-1:0]     dead_band_pa;
    logic [PressureWidth-1:0] baseline_pa;
  } cfg_t;

  typedef struct packed {
    event_t                         cycle_event;
    logic [TimeWidth-1:0]           cycle_ms;
    logic [CountWidth-1:0]          breath_count;
    logic signed [SlopeWidth-1:0]   slope_q4;
    logic signed [RelWidth-1:0]     relative_pa;
    logic signed [SectorWidth-1:0]  sector;
  } result_t;

endpackage

/* src/bpd_cfg_regs.sv */
module bpd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bpd_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bpd_pkg::CfgDataWidth-1:0]    cfg_data,
  output bpd_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline_pa  <= bpd_pkg::BASELINE_RESET;
      cfg.dead_band_pa <= bpd_pkg::DEAD_BAND_RESET;
      cfg.min_cycle_ms <= bpd_pkg::MIN_CYCLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpd_pkg::REG_BASELINE:  cfg.baseline_pa  <= cfg_data;
        bpd_pkg::REG_DEAD_BAND: cfg.dead_band_pa <= cfg_data[bpd_pkg::BandWidth-1:0];
        bpd_pkg::REG_MIN_CYCLE: cfg.min_cycle_ms <= cfg_data[bpd_pkg::MinCycleWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/bpd_core.sv */
module bpd_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [bpd_pkg::PressureWidth-1:0]  pressure_pa,
  input  logic [bpd_pkg::TimeWidth-1:0]      time_ms,
  input  bpd_pkg::cfg_t                      cfg,
  output bpd_pkg::result_t                   result
);

  logic signed [bpd_pkg::RelWidth-1:0]    prev_relative;
  logic signed [bpd_pkg::SlopeWidth-1:0]  prev_slope;
  logic signed [bpd_pkg::SectorWidth-1:0] current_sector;
  logic                                   breath_started;
  logic [bpd_pkg::TimeWidth-1:0]          cycle_start_ms;
  logic [bpd_pkg::CountWidth-1:0]         breaths;

  logic signed [bpd_pkg::RelWidth-1:0]    rel;
  logic signed [bpd_pkg::RelWidth:0]      delta;
  logic signed [bpd_pkg::SlopeWidth+1:0]  slope_sum;
  logic signed [bpd_pkg::SlopeWidth+1:0]  slope_half;
  logic signed [bpd_pkg::SlopeWidth-1:0]  slope;
  logic [bpd_pkg::RelWidth-1:0]           abs_rel;
  logic [bpd_pkg::SlopeWidth-1:0]         abs_slope;
  logic                                   rel_in_band;
  logic                                   slope_in_band;
  logic signed [bpd_pkg::SectorWidth-1:0] sector_next;
  logic                                   cycle_entry;
  logic                                   start_first;
  logic                                   cycle_close;
  logic [bpd_pkg::TimeWidth-1:0]          cyc;
  logic                                   cyc_short;
  logic [bpd_pkg::CountWidth-1:0]         breaths_next;
  bpd_pkg::event_t                        ev;

  always_comb begin
    rel = $signed({1'b0, pressure_pa}) - $signed({1'b0, cfg.baseline_pa});
    delta = $signed({rel[bpd_pkg::RelWidth-1], rel})
          - $signed({prev_relative[bpd_pkg::RelWidth-1], prev_relative});
    slope_sum = $signed({{2{prev_slope[bpd_pkg::SlopeWidth-1]}}, prev_slope})
              + $signed({{2{delta[bpd_pkg::RelWidth]}}, delta, 4'b0000});
    slope_half = slope_sum >>> 1;
    slope = slope_half[bpd_pkg::SlopeWidth-1:0];

    abs_rel = rel[bpd_pkg::RelWidth-1] ? 18'(-rel) : 18'(rel);
    abs_slope = slope[bpd_pkg::SlopeWidth-1] ? 23'(-slope) : 23'(slope);
    rel_in_band = abs_rel < {8'd0, cfg.dead_band_pa};
    slope_in_band = abs_slope < {9'd0, cfg.dead_band_pa, 4'b0000};

    priority if (rel_in_band) begin
      sector_next = slope_in_band ? bpd_pkg::SEC_REST : current_sector;
    end else if (rel < 0 && slope < 0) begin
      sector_next = bpd_pkg::SEC_FALL;
    end else if (rel < 0 && slope > 0) begin
      sector_next = bpd_pkg::SEC_LOW_RISE;
    end else if (rel > 0 && slope > 0) begin
      sector_next = bpd_pkg::SEC_RISE;
    end else if (rel > 0 && slope < 0) begin
      sector_next = bpd_pkg::SEC_HIGH_FALL;
    end else begin
      sector_next = bpd_pkg::SEC_REST;
    end

    cycle_entry = (sector_next == bpd_pkg::SEC_FALL)
               && (current_sector == bpd_pkg::SEC_REST
                   || current_sector == bpd_pkg::SEC_HIGH_FALL);
    start_first = !breath_started && sector_next == bpd_pkg::SEC_FALL
               && current_sector == bpd_pkg::SEC_REST;
    cycle_close = breath_started && cycle_entry;
    cyc = time_ms - cycle_start_ms;
    cyc_short = cyc < {16'd0, cfg.min_cycle_ms};

    breaths_next = breaths;
    ev = bpd_pkg::EV_NONE;
    if (cycle_close) begin
      if (cyc_short) begin
        ev = bpd_pkg::EV_SHORT;
      end else begin
        ev = bpd_pkg::EV_BREATH;
        if (breaths != bpd_pkg::COUNT_MAX) begin
          breaths_next = breaths + 16'd1;
        end
      end
    end

    result.sector       = sector_next;
    result.relative_pa  = rel;
    result.slope_q4     = slope;
    result.breath_count = breaths_next;
    result.cycle_ms     = cycle_close ? cyc : '0;
    result.cycle_event  = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_relative  <= '0;
      prev_slope     <= '0;
      current_sector <= bpd_pkg::SEC_REST;
      breath_started <= 1'b0;
      cycle_start_ms <= '0;
      breaths        <= '0;
    end else if (step) begin
      prev_relative  <= rel;
      prev_slope     <= slope;
      current_sector <= sector_next;
      breaths        <= breaths_next;
      if (start_first || cycle_close) begin
        cycle_start_ms <= time_ms;
        breath_started <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_event_needs_fall: assert property (@(posedge clk) disable iff (rst)
    result.cycle_event != bpd_pkg::EV_NONE |-> result.sector == bpd_pkg::SEC_FALL)
    else $error("cycle event without entry into the falling sector");

  a_no_event_no_length: assert property (@(posedge clk) disable iff (rst)
    result.cycle_event == bpd_pkg::EV_NONE |-> result.cycle_ms == '0)
    else $error("cycle length reported without a cycle event");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    step && breaths == bpd_pkg::COUNT_MAX |=> breaths == bpd_pkg::COUNT_MAX)
    else $error("breath count wrapped");

  a_start_latched: assert property (@(posedge clk) disable iff (rst)
    breath_started |=> breath_started)
    else $error("breath start flag cleared outside reset");
`endif

endmodule

/* src/breath_phase_detector_unit.sv */
// Channel   Direction  Word contents (lowest bits first)
// s_axis    in         pressure_pa[16:0], time_ms[31:0], zero fill to 56 bits
// m_axis    out        sector, relative_pa, slope_q4, breath_count, cycle_ms,
//                      cycle_event, zero fill to 96 bits
// cfg       in         write enable, register index, write data
//
// One word is accepted per cycle unless the output stalls; its result is offered from the output register.
// The word is registered on input, and its result is computed from it and registered on output.
// Reset is synchronous; it clears the pipeline, the breath state and restores the registers.
// A stalled output holds its word while one more input word waits in the input register.
module breath_phase_detector_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pressure_pa [16:0], time_ms [48:17], zeros [55:49]
  input  logic [bpd_pkg::InDataWidth-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sector [2:0], relative_pa [20:3], slope_q4 [43:21], breath_count [59:44],
  // cycle_ms [91:60], cycle_event [93:92], zeros [95:94]
  output logic [bpd_pkg::OutDataWidth-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [bpd_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bpd_pkg::CfgDataWidth-1:0]    cfg_data
);

  bpd_pkg::cfg_t                       cfg;
  bpd_pkg::result_t                    result;
  bpd_pkg::result_t                    out_word;
  logic                                in_full;
  logic [bpd_pkg::PressureWidth-1:0]   in_pressure;
  logic [bpd_pkg::TimeWidth-1:0]       in_time;
  logic                                move;

  assign move = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || move;

  bpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .pressure_pa (in_pressure),
    .time_ms     (in_time),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_pressure <= s_axis_tdata[bpd_pkg::PressureWidth-1:0];
      in_time     <= s_axis_tdata[bpd_pkg::PressureWidth +: bpd_pkg::TimeWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_full;
    end
    if (move) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = {2'b00, out_word};

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_full && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_move_fills_output: assert property (@(posedge clk) disable iff (rst)
    move |=> m_axis_tvalid)
    else $error("word moved to output but output not valid");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_full && !move |=> in_full && $stable(in_pressure) && $stable(in_time))
    else $error("waiting input word lost or changed");
`endif

endmodule

/* tb/bpd_checker.sv */
module bpd_checker
  import bpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [InDataWidth-1:0]   s_axis_tdata,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [OutDataWidth-1:0]  m_axis_tdata,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output int                       pending,
  output int                       errors,
  output int                       words_checked,
  output int                       breaths_seen,
  output int                       alarms_seen,
  output int                       top_count
);

  localparam int ResultBits = $bits(result_t);

  logic [PressureWidth-1:0]      baseline;
  logic [BandWidth-1:0]          band;
  logic [MinCycleWidth-1:0]      min_cycle;
  logic signed [RelWidth-1:0]    last_rel;
  logic signed [SlopeWidth-1:0]  last_slope;
  logic signed [SectorWidth-1:0] sector_now;
  logic                          in_cycle;
  logic [TimeWidth-1:0]          cycle_start;
  logic [CountWidth-1:0]         breath_total;
  result_t                       expected_q[$];
  int                            n_err;
  int                            n_checked;
  int                            n_breaths;
  int                            n_alarms;
  int                            n_peak;

  initial begin
    n_err = 0;
    n_checked = 0;
    n_breaths = 0;
    n_alarms = 0;
    n_peak = 0;
    pending = 0;
    errors = 0;
    words_checked = 0;
    breaths_seen = 0;
    alarms_seen = 0;
    top_count = 0;
  end

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_sample(input logic [PressureWidth-1:0] p,
                                input logic [TimeWidth-1:0] t,
                                output result_t r);
    int rel;
    int delta;
    int slope;
    int lim;
    logic signed [SectorWidth-1:0] sec;
    logic signed [SectorWidth-1:0] was;
    logic [TimeWidth-1:0] cyc;
    event_t ev;
    rel = int'(p) - int'(baseline);
    delta = rel - int'(last_rel);
    slope = (int'(last_slope) + delta * 16) >>> 1;
    lim = int'(band);
    was = sector_now;
    sec = sector_now;
    cyc = '0;
    ev = EV_NONE;
    if (magnitude(rel) < lim) begin
      if (magnitude(slope) < lim * 16) sec = SEC_REST;
    end else if (rel < 0 && slope < 0) begin
      sec = SEC_FALL;
    end else if (rel < 0 && slope > 0) begin
      sec = SEC_LOW_RISE;
    end else if (rel > 0 && slope > 0) begin
      sec = SEC_RISE;
    end else if (rel > 0 && slope < 0) begin
      sec = SEC_HIGH_FALL;
    end else begin
      sec = SEC_REST;
    end
    last_rel = RelWidth'(rel);
    last_slope = SlopeWidth'(slope);
    sector_now = sec;
    if (!in_cycle) begin
      if (sec == SEC_FALL && was == SEC_REST) begin
        cycle_start = t;
        in_cycle = 1'b1;
      end
    end else if (sec == SEC_FALL && (was == SEC_REST || was == SEC_HIGH_FALL)) begin
      cyc = t - cycle_start;
      cycle_start = t;
      if (cyc < TimeWidth'(min_cycle)) begin
        ev = EV_SHORT;
      end else begin
        if (breath_total != COUNT_MAX) breath_total++;
        ev = EV_BREATH;
      end
    end
    r.sector = sec;
    r.relative_pa = RelWidth'(rel);
    r.slope_q4 = SlopeWidth'(slope);
    r.breath_count = breath_total;
    r.cycle_ms = cyc;
    r.cycle_event = ev;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit bad;
    if (rst) begin
      baseline = BASELINE_RESET;
      band = DEAD_BAND_RESET;
      min_cycle = MIN_CYCLE_RESET;
      last_rel = '0;
      last_slope = '0;
      sector_now = SEC_REST;
      in_cycle = 1'b0;
      cycle_start = '0;
      breath_total = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASELINE:  baseline = cfg_data[PressureWidth-1:0];
          REG_DEAD_BAND: band = cfg_data[BandWidth-1:0];
          REG_MIN_CYCLE: min_cycle = cfg_data[MinCycleWidth-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[ResultBits-1:0]);
        n_checked++;
        if (got.cycle_event == EV_BREATH) n_breaths++;
        if (got.cycle_event == EV_SHORT) n_alarms++;
        if (int'(got.breath_count) > n_peak) n_peak = int'(got.breath_count);
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("Unexpected result word %h with nothing outstanding", m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          bad = (got.sector !== want.sector) ||
                (got.relative_pa !== want.relative_pa) ||
                (got.slope_q4 !== want.slope_q4) ||
                (got.breath_count !== want.breath_count) ||
                (got.cycle_ms !== want.cycle_ms) ||
                (got.cycle_event !== want.cycle_event) ||
                (m_axis_tdata[OutDataWidth-1:ResultBits] !== '0);
          if (bad) begin
            n_err++;
            if (n_err <= 10)
              $display("Mismatch on word %0d (expected/actual): sector %0d/%0d ",
                       n_checked, want.sector, got.sector,
                       "relative %0d/%0d slope %0d/%0d count %0d/%0d cycle %0d/%0d ",
                       want.relative_pa, got.relative_pa, want.slope_q4, got.slope_q4,
                       want.breath_count, got.breath_count, want.cycle_ms, got.cycle_ms,
                       "event %0d/%0d fill %b",
                       want.cycle_event, got.cycle_event,
                       m_axis_tdata[OutDataWidth-1:ResultBits]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tdata[PressureWidth-1:0],
                       s_axis_tdata[PressureWidth +: TimeWidth], want);
        expected_q.push_back(want);
      end
    end
    pending <= expected_q.size();
    errors <= n_err;
    words_checked <= n_checked;
    breaths_seen <= n_breaths;
    alarms_seen <= n_alarms;
    top_count <= n_peak;
  end

endmodule

/* tb/tb_breath_phase_detector_unit.sv */
module tb_breath_phase_detector_unit;
  import bpd_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 300;
  localparam int NoiseShare = 10;
  localparam int PhaseWords = 190;
  localparam int PressureMax = (1 << PressureWidth) - 1;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // pressure_pa, time_ms, zero fill
  logic [InDataWidth-1:0]   s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // sector, relative_pa, slope_q4, breath_count, cycle_ms, cycle_event, zero fill
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  int pending;
  int errors;
  int words_checked;
  int breaths_seen;
  int alarms_seen;
  int top_count;

  bit                   tx_gaps;
  bit                   rx_free;
  int                   hold_requests;
  int                   base_now;
  int                   n_sent;
  logic [TimeWidth-1:0] clock_ms;

  breath_phase_detector_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bpd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .errors        (errors),
    .words_checked (words_checked),
    .breaths_seen  (breaths_seen),
    .alarms_seen   (alarms_seen),
    .top_count     (top_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
    $display("FAIL");
    $finish;
  end

  function automatic int pick_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: random ready/stall runs, a free-running mode, and long hold-offs on request.
  initial begin
    int seen;
    int run_left;
    bit ready_run;
    seen = 0;
    run_left = 0;
    ready_run = 1'b1;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_free) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_run = ($urandom_range(0, 3) != 0);
          run_left = pick_span();
        end
        m_axis_tready <= ready_run;
        run_left--;
      end
    end
  end

  task automatic send_word(input logic [PressureWidth-1:0] p, input logic [TimeWidth-1:0] t);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 1) == 1) ? pick_span() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataWidth - PressureWidth - TimeWidth){1'b0}}, t, p};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_rel(input int rel, input logic [TimeWidth-1:0] t);
    int v;
    v = base_now + rel;
    if (v < 0) v = 0;
    else if (v > PressureMax) v = PressureMax;
    send_word(PressureWidth'(v), t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Spare upper bits of the write data are filled at random; the block keeps only its width.
  task automatic set_config(input logic [PressureWidth-1:0] base,
                            input logic [BandWidth-1:0] band,
                            input logic [MinCycleWidth-1:0] minc);
    cfg_we <= 1'b1;
    cfg_index <= REG_BASELINE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_DEAD_BAND;
    cfg_data <= {7'($urandom), band};
    @(posedge clk);
    cfg_index <= REG_MIN_CYCLE;
    cfg_data <= {1'($urandom), minc};
    @(posedge clk);
    cfg_we <= 1'b0;
    base_now = int'(base);
  endtask

  // Hand-built breaths on the reset settings: a zero slope outside the band, an entry
  // from the high fall before any cycle, a held sector in the band, the first entry,
  // a short cycle and a counted breath across the timestamp wrap.
  task automatic directed_breaths();
    int wave_rel [18];
    logic [TimeWidth-1:0] wave_ms [18];
    wave_rel = '{0, 100, 50, 100, 40, -100, 0, 0, -100, 0, 0, 0, -100, 100, 40, 40, 20, -100};
    wave_ms = '{32'd100, 32'd200, 32'd300, 32'd400, 32'd500, 32'd600, 32'd700, 32'd800,
                32'hFFFF_FC00, 32'hFFFF_FC80, 32'hFFFF_FD00, 32'hFFFF_FD80, 32'hFFFF_FE00,
                32'hFFFF_FE80, 32'hFFFF_FF00, 32'hFFFF_FF80, 32'hFFFF_FFFF, 32'h0000_0400};
    for (int i = 0; i < 18; i++) send_rel(wave_rel[i], wave_ms[i]);
  endtask

  task automatic directed_extremes();
    drain();
    set_config('0, '0, '1);
    send_word('0, '0);
    send_word(PressureWidth'(PressureMax), '1);
    send_word('0, 32'h8000_0000);
    drain();
    set_config(PressureWidth'(PressureMax), '1, '0);
    send_word('0, 32'd1);
    send_word(PressureWidth'(PressureMax), 32'd2);
    send_word('0, 32'd3);
  endtask

  // Breath-shaped traffic: ramps between rest, a dip and a rise with jitter, mixed with
  // raw samples. Halfway through, either the receiver holds off or the sender drains.
  task automatic run_phase(input int n_words, input logic [PressureWidth-1:0] base,
                           input logic [BandWidth-1:0] band,
                           input logic [MinCycleWidth-1:0] minc,
                           input logic [TimeWidth-1:0] t0, input bit with_hold);
    int done;
    int start_rel;
    int end_rel;
    int amp;
    int steps;
    int jmax;
    int rel;
    bit midway;
    drain();
    set_config(base, band, minc);
    clock_ms = t0;
    done = 0;
    start_rel = 0;
    midway = 1'b0;
    jmax = int'(band) / 2;
    while (done < n_words) begin
      if (!midway && done >= n_words / 2) begin
        midway = 1'b1;
        if (with_hold) begin
          hold_requests <= hold_requests + 1;
          tx_gaps = 1'b0;
        end else begin
          drain();
        end
      end
      if (with_hold && midway && done >= n_words / 2 + 40) tx_gaps = 1'b1;
      if ($urandom_range(0, 99) < NoiseShare) begin
        send_word(PressureWidth'($urandom), $urandom);
        done++;
      end else begin
        if ($urandom_range(0, 4) != 0) amp = $urandom_range(int'(band) + 1, 8 * int'(band) + 40);
        else amp = $urandom_range(0, 70000);
        case ($urandom_range(0, 4))
          0, 1: end_rel = 0;
          2: end_rel = -amp;
          3: end_rel = amp;
          default: end_rel = amp / 2;
        endcase
        steps = $urandom_range(1, 6);
        for (int i = 1; i <= steps && done < n_words; i++) begin
          rel = start_rel + (end_rel - start_rel) * i / steps;
          rel += $urandom_range(0, 2 * jmax) - jmax;
          clock_ms += $urandom_range(5, 250);
          send_rel(rel, clock_ms);
          done++;
        end
        start_rel = end_rel;
      end
    end
    tx_gaps = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_BASELINE;
    cfg_data <= '0;
    rx_free <= 1'b0;
    hold_requests <= 0;
    tx_gaps = 1'b1;
    base_now = int'(BASELINE_RESET);
    n_sent = 0;
    clock_ms = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_breaths();
    directed_extremes();

    run_phase(PhaseWords, BASELINE_RESET, BandWidth'($urandom_range(5, 40)),
              MinCycleWidth'($urandom_range(500, 2500)), $urandom, 1'b1);
    run_phase(PhaseWords, '0, '1, '1, 32'hFFFF_FFFF - $urandom_range(0, 30000), 1'b0);
    run_phase(PhaseWords, PressureWidth'(PressureMax), '0, '0, $urandom, 1'b0);
    run_phase(PhaseWords, PressureWidth'($urandom), BandWidth'($urandom),
              MinCycleWidth'($urandom), $urandom, 1'b0);
    run_phase(PhaseWords, PressureWidth'(65536), BandWidth'($urandom_range(1, 30)),
              MinCycleWidth'($urandom_range(0, 3000)),
              32'hFFFF_FFFF - $urandom_range(0, 20000), 1'b1);
    run_phase(PhaseWords, PressureWidth'($urandom), BandWidth'($urandom_range(0, 60)),
              MinCycleWidth'($urandom_range(0, 4000)), $urandom, 1'b0);

    drain();

    $display("Sent %0d words and checked %0d results across nine register settings.",
             n_sent, words_checked);
    $display("Saw %0d counted breaths and %0d short-cycle alarms; the count peaked at %0d.",
             breaths_seen, alarms_seen, top_count);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
